@@ src/tdh_pkg.sv @@
`timescale 1ns / 1ps

package tdh_pkg;

    localparam int STATE_W  = 6;
    localparam int CFG_W    = 7;
    localparam int PROB_W   = 17;
    localparam int OUT_CNT_W = 32;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
    } t_in_word;

    typedef struct packed {
        logic [PROB_W-1:0]    probability;
        logic [OUT_CNT_W-1:0] matching_count;
        logic [OUT_CNT_W-1:0] total_count;
        logic [1:0]           status;
    } t_out_word;

endpackage

@@ src/tdh_ram.sv @@
`timescale 1ns / 1ps

module tdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/tdh_div.sv @@
`timescale 1ns / 1ps

module tdh_div #(
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [COUNT_BITS-1:0]   i_num,
    input  logic [COUNT_BITS-1:0]   i_den,
    output logic                    o_done,
    output logic [FRACTION_BITS:0]  o_quot
);

    localparam int STEP_W = $clog2(FRACTION_BITS);

    logic [COUNT_BITS:0]    r_rem;
    logic [COUNT_BITS-1:0]  r_den;
    logic [FRACTION_BITS:0] r_quot;
    logic [STEP_W-1:0]      r_step;
    logic                   r_run;
    logic                   r_done;

    logic [COUNT_BITS:0] n_shift;
    logic                n_ge;
    logic                n_first;

    always_comb begin
        n_shift = {r_rem[COUNT_BITS-1:0], 1'b0};
        n_ge    = (n_shift >= {1'b0, r_den});
        n_first = (i_num >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                if (r_step == STEP_W'(FRACTION_BITS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= n_first ? {1'b0, i_num - i_den} : {1'b0, i_num};
            r_quot <= {{FRACTION_BITS{1'b0}}, n_first};
        end else if (r_run) begin
            r_rem  <= n_ge ? (n_shift - {1'b0, r_den}) : n_shift;
            r_quot <= {r_quot[FRACTION_BITS-1:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ src/transition_distance_histogram_core.sv @@
`timescale 1ns / 1ps
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------
// item in   | start, busy (accept: start & !busy) | i_item (t_in_word)
// result    | o_strobe, one cycle, no stall  | o_result (t_out_word)
// config    | i_cfg_valid, o_cfg_ready       | i_cfg_data (states_in_use)
//
// a record takes one memory read, then the read-modify-write with the result
// registered out
// a query that divides runs the restoring divider (one quotient bit per cycle)
// after the count read; other queries end with the count read
// after reset the count memory, all 2 * 2^clog2(MAX_STATES) entries (128 by default),
// is cleared one entry per cycle with busy high; config writes are taken throughout
// the result strobe lasts one cycle and cannot be held off

module transition_distance_histogram_core
    import tdh_pkg::*;
#(
    parameter int MAX_STATES    = 64,
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_word         i_item,
    output logic             o_strobe,
    output t_out_word        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW        = $clog2(MAX_STATES);
    localparam int RAW       = AW + 1;
    localparam int RAM_DEPTH = 2 * (1 << AW);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DIV
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]      r_states;
    logic [RAW-1:0]        r_clr;
    logic                  r_op;
    logic                  r_bad;
    logic                  r_self;
    logic [RAW-1:0]        r_addr;
    logic [COUNT_BITS-1:0] r_self_count;
    logic [COUNT_BITS-1:0] r_all;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_strobe;
    t_out_word             r_result;

    logic                  n_accept;
    logic                  n_a_ok;
    logic                  n_b_ok;
    logic [STATE_W-1:0]    n_dist;
    logic [RAW-1:0]        n_raddr;
    logic                  n_we;
    logic [RAW-1:0]        n_waddr;
    logic [COUNT_BITS-1:0] n_wdata;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] n_cnt_inc;
    logic [COUNT_BITS-1:0] n_all_inc;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  div_start;
    logic                  div_done;
    logic [FRACTION_BITS:0] div_quot;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        sat_out = (w[63:32] != 32'd0) ? '1 : w[31:0];
    endfunction

    assign n_accept = start && !busy;

    always_comb begin
        n_a_ok  = ({1'b0, i_item.from_state} < r_states)
                  && (32'(i_item.from_state) < MAX_STATES);
        n_b_ok  = ({1'b0, i_item.to_state} < r_states)
                  && (32'(i_item.to_state) < MAX_STATES);
        n_dist  = (i_item.to_state > i_item.from_state)
                  ? (i_item.to_state - i_item.from_state)
                  : (i_item.from_state - i_item.to_state);
        n_raddr = {(i_item.to_state < i_item.from_state), AW'(n_dist)};

        n_cnt     = r_self ? r_self_count : ram_rdata;
        n_cnt_inc = sat_inc(n_cnt);
        n_all_inc = sat_inc(r_all);

        n_we    = 1'b0;
        n_waddr = r_addr;
        n_wdata = n_cnt_inc;
        if (r_state == S_CLEAR) begin
            n_we    = 1'b1;
            n_waddr = r_clr;
            n_wdata = '0;
        end else if (r_state == S_READ && !r_bad && r_op == OP_RECORD && !r_self) begin
            n_we = 1'b1;
        end

        div_start = (r_state == S_READ) && !r_bad && (r_op == OP_QUERY) && (r_all != '0);
    end

    tdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (ram_rdata)
    );

    tdh_div #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_cnt),
        .i_den   (r_all),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_states     <= CFG_W'(1);
            r_self_count <= '0;
            r_all        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_states <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_strobe <= 1'b0;
                    r_clr    <= r_clr + 1'b1;
                    if (r_clr == RAW'(RAM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (n_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (div_start) begin
                        r_strobe <= 1'b0;
                        r_cnt    <= n_cnt;
                        r_state  <= S_DIV;
                    end else begin
                        r_strobe             <= 1'b1;
                        r_state              <= S_IDLE;
                        r_result.probability <= '0;
                        if (r_bad) begin
                            r_result.matching_count <= '0;
                            r_result.total_count    <= sat_out(r_all);
                            r_result.status         <= STATUS_RANGE;
                        end else if (r_op == OP_RECORD) begin
                            if (r_self) begin
                                r_self_count <= n_cnt_inc;
                            end
                            r_all                   <= n_all_inc;
                            r_result.matching_count <= sat_out(n_cnt_inc);
                            r_result.total_count    <= sat_out(n_all_inc);
                            r_result.status         <= STATUS_OK;
                        end else begin
                            r_result.matching_count <= '0;
                            r_result.total_count    <= sat_out(r_all);
                            r_result.status         <= STATUS_ZERO;
                        end
                    end
                end
                S_DIV: begin
                    r_strobe <= div_done;
                    if (div_done) begin
                        r_result.probability    <= PROB_W'(div_quot);
                        r_result.matching_count <= sat_out(r_cnt);
                        r_result.total_count    <= sat_out(r_all);
                        r_result.status         <= STATUS_OK;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op   <= i_item.operation;
            r_bad  <= !(n_a_ok && n_b_ok);
            r_self <= (i_item.from_state == i_item.to_state);
            r_addr <= n_raddr;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule
